// ----- rtl/core/dsdo_pkg.sv -----
package dsdo_pkg;

  localparam int DEF_STORE_DEPTH  = 256;
  localparam int DEF_RECORD_WIDTH = 64;

  localparam int CAP_W      = 9;
  localparam int GCAP_W     = 10;
  localparam int CNT_W      = 32;
  localparam int IDX_W      = 3;
  localparam int CFG_DATA_W = 10;

  // Output count fields, fixed by the result layout
  localparam int TOTAL_OUT_W = 10;
  localparam int FILL_OUT_W  = 9;

  localparam logic                PRIMARY_AVAILABLE_RST = 1'b1;
  localparam logic [CAP_W-1:0]    PRIMARY_CAPACITY_RST  = 9'd256;
  localparam logic [CAP_W-1:0]    FALLBACK_CAPACITY_RST = 9'd256;
  localparam logic [GCAP_W-1:0]   GLOBAL_CAPACITY_RST   = 10'd256;

  // Threshold ceil(0.8 x cap) = (4 x cap + 4) / 5, by reciprocal multiply
  localparam int THR_PROD_W  = 24;
  localparam int DIV5_RECIP  = 3277;
  localparam int DIV5_SHIFT  = 14;

  typedef enum logic [IDX_W-1:0] {
    REG_PRIMARY_AVAILABLE = 3'd0,
    REG_PRIMARY_CAPACITY  = 3'd1,
    REG_FALLBACK_CAPACITY = 3'd2,
    REG_GLOBAL_CAPACITY   = 3'd3
  } cfg_index_t;

  typedef struct packed {
    logic               primary_available;
    logic [CAP_W-1:0]   primary_capacity;
    logic [CAP_W-1:0]   fallback_capacity;
    logic [GCAP_W-1:0]  global_capacity;
  } cfg_t;

  typedef struct packed {
    logic                   pop_valid;
    logic                   push_no_eviction;
    logic                   warning_event;
    logic [TOTAL_OUT_W-1:0] total_count;
    logic [FILL_OUT_W-1:0]  primary_count;
    logic [FILL_OUT_W-1:0]  fallback_count;
    logic [CNT_W-1:0]       eviction_total;
    logic [CNT_W-1:0]       io_error_total;
    logic [CNT_W-1:0]       warning_total;
  } res_t;

  function automatic logic [CAP_W-1:0] warn_threshold(input logic [CAP_W-1:0] cap);
    logic [THR_PROD_W-1:0] prod;
    prod = (THR_PROD_W'(cap) * THR_PROD_W'(4) + THR_PROD_W'(4)) * THR_PROD_W'(DIV5_RECIP);
    return CAP_W'(prod >> DIV5_SHIFT);
  endfunction

endpackage

// ----- rtl/core/dsdo_store.sv -----
module dsdo_store #(
  parameter int DEPTH = dsdo_pkg::DEF_STORE_DEPTH,
  parameter int WIDTH = dsdo_pkg::DEF_RECORD_WIDTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/dsdo_engine.sv -----
module dsdo_engine #(
  parameter int STORE_DEPTH  = dsdo_pkg::DEF_STORE_DEPTH,
  parameter int RECORD_WIDTH = dsdo_pkg::DEF_RECORD_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dsdo_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [RECORD_WIDTH-1:0]        in_rec,
  input  logic                           out_free,
  output logic                           res_load,
  output dsdo_pkg::res_t                 res,
  output logic [RECORD_WIDTH-1:0]        res_data,
  output logic                           p_wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0] p_wr_addr,
  output logic [RECORD_WIDTH-1:0]        p_wr_data,
  output logic                           p_rd_en,
  output logic [$clog2(STORE_DEPTH)-1:0] p_rd_addr,
  input  logic [RECORD_WIDTH-1:0]        p_rd_data,
  output logic                           f_wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0] f_wr_addr,
  output logic [RECORD_WIDTH-1:0]        f_wr_data,
  output logic                           f_rd_en,
  output logic [$clog2(STORE_DEPTH)-1:0] f_rd_addr,
  input  logic [RECORD_WIDTH-1:0]        f_rd_data
);

  import dsdo_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam int TW = FW + 1;
  localparam int XW = (TW > GCAP_W) ? TW + 1 : GCAP_W + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(STORE_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVICT = 5'b00010,
    ST_PUT   = 5'b00100,
    ST_TAKE  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [RECORD_WIDTH-1:0] rec;
  logic [AW-1:0]     p_head, p_head_next, f_head, f_head_next;
  logic [FW-1:0]     p_fill, p_fill_next, f_fill, f_fill_next;
  logic              above, above_next;
  logic [CNT_W-1:0]  evict_cnt, evict_cnt_next, io_cnt, io_cnt_next, warn_cnt, warn_cnt_next;
  logic              pop_valid, pop_valid_next, no_evict, no_evict_next;
  logic              warned, warned_next, from_fb, from_fb_next;

  logic [XW-1:0]     pcap_x, fcap_x, gcap_x, thr_x;
  logic [XW-1:0]     p_fill_x, f_fill_x, total_x;
  logic [XW-1:0]     n_ev, np_ev, nf_ev, f_left;
  logic              put_primary, drop;
  logic [AW-1:0]     head_sel, head_a;
  logic [XW-1:0]     fill_sel, cap_sel, fill_a;
  logic [AW-1:0]     put_addr;
  logic              fb_now;

  // Reduce a sum below twice the depth to a ring index
  function automatic logic [AW-1:0] wrap(input logic [XW-1:0] s);
    if (s >= DEPTH_X) begin
      return AW'(s - DEPTH_X);
    end
    return AW'(s);
  endfunction

  function automatic logic [XW-1:0] eff_cap(input logic [CAP_W-1:0] c);
    if (c == '0) begin
      return XW'(1);
    end
    if (XW'(c) > DEPTH_X) begin
      return DEPTH_X;
    end
    return XW'(c);
  endfunction

  assign pcap_x   = eff_cap(cfg.primary_capacity);
  assign fcap_x   = eff_cap(cfg.fallback_capacity);
  assign gcap_x   = (cfg.global_capacity == '0) ? XW'(1) : XW'(cfg.global_capacity);
  assign thr_x    = XW'(warn_threshold(CAP_W'(fcap_x)));
  assign p_fill_x = XW'(p_fill);
  assign f_fill_x = XW'(f_fill);
  assign total_x  = p_fill_x + f_fill_x;

  // Eviction run in closed form: primary first, the rest from fallback
  assign n_ev   = total_x - gcap_x + XW'(1);
  assign np_ev  = (n_ev > p_fill_x) ? p_fill_x : n_ev;
  assign nf_ev  = n_ev - np_ev;
  assign f_left = f_fill_x - nf_ev;

  // Append: drop the target store's oldest once when it is full
  assign put_primary = cfg.primary_available;
  assign head_sel    = put_primary ? p_head : f_head;
  assign fill_sel    = put_primary ? p_fill_x : f_fill_x;
  assign cap_sel     = put_primary ? pcap_x : fcap_x;
  assign drop        = fill_sel >= cap_sel;
  assign head_a      = drop ? wrap(XW'(head_sel) + XW'(1)) : head_sel;
  assign fill_a      = drop ? fill_sel - XW'(1) : fill_sel;
  assign put_addr    = wrap(XW'(head_a) + fill_a);
  assign fb_now      = (fill_a + XW'(1)) >= thr_x;

  assign p_wr_addr = put_addr;
  assign f_wr_addr = put_addr;
  assign p_wr_data = rec;
  assign f_wr_data = rec;
  assign p_rd_addr = p_head;
  assign f_rd_addr = f_head;

  always_comb begin
    state_next     = state;
    p_head_next    = p_head;
    f_head_next    = f_head;
    p_fill_next    = p_fill;
    f_fill_next    = f_fill;
    above_next     = above;
    evict_cnt_next = evict_cnt;
    io_cnt_next    = io_cnt;
    warn_cnt_next  = warn_cnt;
    pop_valid_next = pop_valid;
    no_evict_next  = no_evict;
    warned_next    = warned;
    from_fb_next   = from_fb;
    in_ready       = 1'b0;
    res_load       = 1'b0;
    p_wr_en        = 1'b0;
    f_wr_en        = 1'b0;
    p_rd_en        = 1'b0;
    f_rd_en        = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pop_valid_next = 1'b0;
          no_evict_next  = 1'b0;
          warned_next    = 1'b0;
          from_fb_next   = 1'b0;
          state_next     = in_op ? ST_TAKE : ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (total_x >= gcap_x) begin
          p_fill_next    = FW'(p_fill_x - np_ev);
          p_head_next    = wrap(XW'(p_head) + np_ev);
          f_fill_next    = FW'(f_left);
          f_head_next    = wrap(XW'(f_head) + nf_ev);
          evict_cnt_next = evict_cnt + CNT_W'(n_ev);
          no_evict_next  = 1'b0;
          if (nf_ev != '0) begin
            // Only the first fallback removal of a run can cross upward
            if (!above && ((f_fill_x - XW'(1)) >= thr_x)) begin
              warn_cnt_next = warn_cnt + CNT_W'(1);
              warned_next   = 1'b1;
            end
            above_next = f_left >= thr_x;
          end
        end else begin
          no_evict_next = 1'b1;
        end
        state_next = ST_PUT;
      end
      ST_PUT: begin
        if (put_primary) begin
          p_wr_en     = 1'b1;
          p_head_next = head_a;
          p_fill_next = FW'(fill_a + XW'(1));
        end else begin
          f_wr_en     = 1'b1;
          f_head_next = head_a;
          f_fill_next = FW'(fill_a + XW'(1));
          io_cnt_next = io_cnt + CNT_W'(1);
          if (fb_now && !above) begin
            warn_cnt_next = warn_cnt + CNT_W'(1);
            warned_next   = 1'b1;
          end
          above_next = fb_now;
        end
        state_next = ST_RESP;
      end
      ST_TAKE: begin
        if (p_fill != '0) begin
          p_rd_en        = 1'b1;
          p_head_next    = wrap(XW'(p_head) + XW'(1));
          p_fill_next    = p_fill - FW'(1);
          pop_valid_next = 1'b1;
        end else if (f_fill != '0) begin
          f_rd_en        = 1'b1;
          f_head_next    = wrap(XW'(f_head) + XW'(1));
          f_fill_next    = f_fill - FW'(1);
          if (!above && ((f_fill_x - XW'(1)) >= thr_x)) begin
            warn_cnt_next = warn_cnt + CNT_W'(1);
            warned_next   = 1'b1;
          end
          above_next     = (f_fill_x - XW'(1)) >= thr_x;
          pop_valid_next = 1'b1;
          from_fb_next   = 1'b1;
        end
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.pop_valid        = pop_valid;
    res.push_no_eviction = no_evict;
    res.warning_event    = warned;
    res.total_count      = TOTAL_OUT_W'(total_x);
    res.primary_count    = FILL_OUT_W'(p_fill_x);
    res.fallback_count   = FILL_OUT_W'(f_fill_x);
    res.eviction_total   = evict_cnt;
    res.io_error_total   = io_cnt;
    res.warning_total    = warn_cnt;
    if (!pop_valid) begin
      res_data = '0;
    end else if (from_fb) begin
      res_data = f_rd_data;
    end else begin
      res_data = p_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      p_head    <= '0;
      f_head    <= '0;
      p_fill    <= '0;
      f_fill    <= '0;
      above     <= 1'b0;
      evict_cnt <= '0;
      io_cnt    <= '0;
      warn_cnt  <= '0;
      pop_valid <= 1'b0;
      no_evict  <= 1'b0;
      warned    <= 1'b0;
      from_fb   <= 1'b0;
    end else begin
      state     <= state_next;
      p_head    <= p_head_next;
      f_head    <= f_head_next;
      p_fill    <= p_fill_next;
      f_fill    <= f_fill_next;
      above     <= above_next;
      evict_cnt <= evict_cnt_next;
      io_cnt    <= io_cnt_next;
      warn_cnt  <= warn_cnt_next;
      pop_valid <= pop_valid_next;
      no_evict  <= no_evict_next;
      warned    <= warned_next;
      from_fb   <= from_fb_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rec <= in_rec;
    end
  end

endmodule

// ----- rtl/core/dual_store_drop_oldest_fifo_unit.sv -----
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tuser = operation, s_tdata = record
// m_*       out        m_tvalid / m_tready  m_tuser = pop_valid, m_tdata = result fields
// cfg_*     in         cfg_valid / cfg_ready cfg_index = register, cfg_data = value
//
// A pop passes through accept, read and respond states and a push through accept, evict,
// append and respond; the result appears on m_tvalid from the result register, and s_tready
// stays low until the response cycle has loaded the result register.
// Evictions of any length finish in the single evict state, worked out from the fill counts.
// The result register lets the next transaction in while a result waits on m_tready;
// the response cycle holds while that register still carries an untaken transaction.
// Synchronous reset empties both stores (fill counts only, no clearing pass) and
// restores the register defaults.
module dual_store_drop_oldest_fifo_unit #(
  parameter int STORE_DEPTH  = dsdo_pkg::DEF_STORE_DEPTH,
  parameter int RECORD_WIDTH = dsdo_pkg::DEF_RECORD_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // record
  input  logic [((RECORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // operation (0 push, 1 pop)
  input  logic                                    s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // pop_data, push_no_eviction, warning_event, total_count, primary_count,
  // fallback_count, eviction_total, io_error_total, warning_total, zero pad
  output logic [((RECORD_WIDTH + 126 + 7) / 8) * 8 - 1:0] m_tdata,
  // pop_valid
  output logic                                    m_tuser,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [dsdo_pkg::IDX_W-1:0]              cfg_index,
  input  logic [dsdo_pkg::CFG_DATA_W-1:0]         cfg_data
);

  import dsdo_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int OUT_W = ((RECORD_WIDTH + 126 + 7) / 8) * 8;

  cfg_t                    cfg;
  res_t                    res;
  logic [RECORD_WIDTH-1:0] res_data;
  logic                    res_load;
  logic                    out_free;

  logic                    p_wr_en, p_rd_en, f_wr_en, f_rd_en;
  logic [AW-1:0]           p_wr_addr, p_rd_addr, f_wr_addr, f_rd_addr;
  logic [RECORD_WIDTH-1:0] p_wr_data, p_rd_data, f_wr_data, f_rd_data;

  // Registers accept every write; an index beyond the list is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.primary_available <= PRIMARY_AVAILABLE_RST;
      cfg.primary_capacity  <= PRIMARY_CAPACITY_RST;
      cfg.fallback_capacity <= FALLBACK_CAPACITY_RST;
      cfg.global_capacity   <= GLOBAL_CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRIMARY_AVAILABLE: cfg.primary_available <= cfg_data[0];
        REG_PRIMARY_CAPACITY:  cfg.primary_capacity  <= cfg_data[CAP_W-1:0];
        REG_FALLBACK_CAPACITY: cfg.fallback_capacity <= cfg_data[CAP_W-1:0];
        REG_GLOBAL_CAPACITY:   cfg.global_capacity   <= cfg_data[GCAP_W-1:0];
        default: ;
      endcase
    end
  end

  dsdo_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (RECORD_WIDTH)
  ) u_primary (
    .clk     (clk),
    .wr_en   (p_wr_en),
    .wr_addr (p_wr_addr),
    .wr_data (p_wr_data),
    .rd_en   (p_rd_en),
    .rd_addr (p_rd_addr),
    .rd_data (p_rd_data)
  );

  dsdo_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (RECORD_WIDTH)
  ) u_fallback (
    .clk     (clk),
    .wr_en   (f_wr_en),
    .wr_addr (f_wr_addr),
    .wr_data (f_wr_data),
    .rd_en   (f_rd_en),
    .rd_addr (f_rd_addr),
    .rd_data (f_rd_data)
  );

  dsdo_engine #(
    .STORE_DEPTH  (STORE_DEPTH),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_rec    (s_tdata[RECORD_WIDTH-1:0]),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .res_data  (res_data),
    .p_wr_en   (p_wr_en),
    .p_wr_addr (p_wr_addr),
    .p_wr_data (p_wr_data),
    .p_rd_en   (p_rd_en),
    .p_rd_addr (p_rd_addr),
    .p_rd_data (p_rd_data),
    .f_wr_en   (f_wr_en),
    .f_wr_addr (f_wr_addr),
    .f_wr_data (f_wr_data),
    .f_rd_en   (f_rd_en),
    .f_rd_addr (f_rd_addr),
    .f_rd_data (f_rd_data)
  );

  // Result register: load when empty or when the held transaction leaves
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tuser <= res.pop_valid;
      m_tdata <= OUT_W'({res.warning_total, res.io_error_total, res.eviction_total,
                         res.fallback_count, res.primary_count, res.total_count,
                         res.warning_event, res.push_no_eviction, res_data});
    end
  end

endmodule
